FILE: rtl/apsc_pkg.sv
// Package for the archive path safety check: widths, byte codes and limits.
`timescale 1ns / 1ps

package apsc_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned POS_W  = 9;
    localparam int unsigned SEG_W  = 2;

    localparam logic [POS_W-1:0]  POS_MAX = 9'd511;
    localparam logic [SEG_W-1:0]  SEG_MAX = 2'd3;
    localparam logic [BYTE_W-1:0] MAX_PATH_BYTES_RST = 8'd255;

    localparam logic [BYTE_W-1:0] CH_SLASH     = 8'h2f;
    localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5c;
    localparam logic [BYTE_W-1:0] CH_COLON     = 8'h3a;
    localparam logic [BYTE_W-1:0] CH_DOT       = 8'h2e;
    localparam logic [BYTE_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [BYTE_W-1:0] CH_DEL       = 8'h7f;
    localparam logic [BYTE_W-1:0] CH_UPPER_A   = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UPPER_Z   = 8'h5a;
    localparam logic [BYTE_W-1:0] CH_LOWER_A   = 8'h61;
    localparam logic [BYTE_W-1:0] CH_LOWER_Z   = 8'h7a;

    typedef logic [BYTE_W-1:0] t_byte;

endpackage

FILE: rtl/archive_path_safety_check_unit.sv
// Top level of the archive path safety check: per-byte rule checks and verdict.
`timescale 1ns / 1ps

// Archive path safety check. A path enters one byte per transaction on the
// input channel, with i_final_byte set on its last byte; exactly one verdict
// transaction (o_path_safe, 1 = safe) leaves per path, none for other bytes.
// The path is rejected for a leading '/' or '\', a drive prefix (letter then
// ':'), any '\', control byte or DEL, an empty inner segment, a "." or ".."
// segment, or more bytes than max_path_bytes (config write, reset 255).
// A single trailing '/' is fine. Rate: one byte per cycle while no final byte
// is held back; a byte is held in the input register, and the verdict appears in the
// output register the cycle after the final byte is processed.
// Non-final bytes keep flowing while a verdict waits on a stalled output; only
// the next final byte is held back until the output register frees up.
// Configuration must only be written while no path is in flight.
module archive_path_safety_check_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  apsc_pkg::t_byte      i_cfg_max_path_bytes,
    // byte input channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  apsc_pkg::t_byte      i_path_byte,
    input  logic                 i_final_byte,
    // verdict output channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_path_safe
);
    import apsc_pkg::*;

    // config register
    t_byte              r_max_bytes;

    // input register
    logic               r_s1_valid;
    t_byte              r_s1_byte;
    logic               r_s1_final;

    // per-path state
    logic [POS_W-1:0]   r_pos;
    logic [SEG_W-1:0]   r_seg_len;
    logic               r_seg_dots;
    logic               r_first_letter;
    logic               r_failed;

    // result register
    logic               r_out_valid;
    logic               r_out_safe;

    // next-state values
    logic [POS_W-1:0]   n_pos;
    logic [SEG_W-1:0]   n_seg_len;
    logic               n_seg_dots;
    logic               n_first_letter;
    logic               n_failed;
    logic               n_safe;

    logic               out_free;
    logic               s1_go;
    logic               is_slash;
    logic               is_letter;
    logic               bad_char;
    logic               dot_seg_now;
    logic               dot_seg_end;

    assign o_cfg_ready = 1'b1;

    // a final byte needs the result register; other bytes never wait on it
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_go      = r_s1_valid && (!r_s1_final || out_free);
    assign o_in_stall = r_s1_valid && !s1_go;

    assign o_out_valid = r_out_valid;
    assign o_path_safe = r_out_safe;

    // byte classification
    assign is_slash  = (r_s1_byte == CH_SLASH);
    assign is_letter = ((r_s1_byte >= CH_UPPER_A) && (r_s1_byte <= CH_UPPER_Z))
                    || ((r_s1_byte >= CH_LOWER_A) && (r_s1_byte <= CH_LOWER_Z));
    assign bad_char  = (r_s1_byte == CH_BACKSLASH) || (r_s1_byte < CH_SPACE)
                    || (r_s1_byte == CH_DEL);

    // "." or ".." segment closed by this '/'
    assign dot_seg_now = r_seg_dots && ((r_seg_len == 2'd1) || (r_seg_len == 2'd2));

    always_comb begin
        n_first_letter = r_first_letter;
        n_failed       = r_failed;

        if (r_pos == '0) begin
            if (is_slash || (r_s1_byte == CH_BACKSLASH)) begin
                n_failed = 1'b1;
            end
            n_first_letter = is_letter;
        end else if (r_pos == POS_W'(1)) begin
            if (r_first_letter && (r_s1_byte == CH_COLON)) begin
                n_failed = 1'b1;
            end
        end

        if (bad_char) begin
            n_failed = 1'b1;
        end

        if (is_slash) begin
            if ((r_seg_len == '0) || dot_seg_now) begin
                n_failed = 1'b1;
            end
            n_seg_len  = '0;
            n_seg_dots = 1'b1;
        end else begin
            n_seg_len  = (r_seg_len == SEG_MAX) ? r_seg_len : r_seg_len + SEG_W'(1);
            n_seg_dots = r_seg_dots && (r_s1_byte == CH_DOT);
        end

        n_pos = (r_pos == POS_MAX) ? r_pos : r_pos + POS_W'(1);
    end

    // end of path closes the last segment for the dot check; an empty one is fine there
    assign dot_seg_end = n_seg_dots && ((n_seg_len == 2'd1) || (n_seg_len == 2'd2));
    assign n_safe = !(n_failed || dot_seg_end || (n_pos > {1'b0, r_max_bytes}));

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_bytes <= MAX_PATH_BYTES_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_bytes <= i_cfg_max_path_bytes;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_s1_byte  <= i_path_byte;
            r_s1_final <= i_final_byte;
        end
    end

    // per-path state, cleared after each final byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos          <= '0;
            r_seg_len      <= '0;
            r_seg_dots     <= 1'b1;
            r_first_letter <= 1'b0;
            r_failed       <= 1'b0;
        end else if (s1_go) begin
            if (r_s1_final) begin
                r_pos          <= '0;
                r_seg_len      <= '0;
                r_seg_dots     <= 1'b1;
                r_first_letter <= 1'b0;
                r_failed       <= 1'b0;
            end else begin
                r_pos          <= n_pos;
                r_seg_len      <= n_seg_len;
                r_seg_dots     <= n_seg_dots;
                r_first_letter <= n_first_letter;
                r_failed       <= n_failed;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && r_s1_final) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_final) begin
            r_out_safe <= n_safe;
        end
    end

    // assertions
    a_final_gives_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_go && r_s1_final |=> o_out_valid)
        else $error("final byte processed without a verdict");

    a_final_clears_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_go && r_s1_final |=> (r_pos == '0) && !r_failed)
        else $error("path state not cleared after final byte");

    a_empty_seg_all_dots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seg_len == '0) |-> r_seg_dots)
        else $error("empty segment without dot flag");

    a_stall_only_when_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_valid && r_s1_final && r_out_valid && i_out_stall)
        else $error("input stalled without a blocked final byte");

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for the archive path safety check unit.
`timescale 1ns / 1ps

module tb;

    import apsc_pkg::*;

    // Run guard, far above the slowest legal run: at most 1126 bytes,
    // random gaps on both sides and one long output hold-off.
    localparam int unsigned CYCLE_LIMIT = 200000;
    // Cycles allowed after the last verdict before a config write or the end.
    localparam int unsigned SETTLE_CYCLES = 6;
    // The receiver holds off once, for this many cycles.
    localparam int unsigned HOLD_CYCLES = 150;
    localparam int unsigned HOLD_AFTER_VERDICTS = 30;

    typedef struct packed {
        t_byte b;
        logic  last;
    } t_path_item;

    // Kinds of damage applied to an otherwise clean random path.
    typedef enum int unsigned {
        FLAW_LEAD_SEP,
        FLAW_DRIVE,
        FLAW_DOT_SEG,
        FLAW_EMPTY_SEG,
        FLAW_BAD_BYTE,
        FLAW_NOISE
    } t_flaw;

    logic  clk        = 1'b0;
    logic  rst_n      = 1'b0;
    logic  cfg_valid  = 1'b0;
    t_byte cfg_data   = '0;
    logic  in_valid   = 1'b0;
    t_byte path_byte  = '0;
    logic  final_byte = 1'b0;
    logic  out_stall  = 1'b0;
    logic  calm       = 1'b0;   // no random gaps on either side while set

    logic  cfg_ready;
    logic  in_stall;
    logic  out_valid;
    logic  path_safe;

    // Pending bytes for the driver, and verdicts still owed by the block.
    t_path_item path_q[$];
    logic       verdict_q[$];

    // Shadow of the block's path state and its configured limit.
    logic [POS_W-1:0] pos_cnt     = '0;
    logic [SEG_W-1:0] seg_len     = '0;
    logic             seg_dots    = 1'b1;
    logic             lead_letter = 1'b0;
    logic             rejected    = 1'b0;
    t_byte            limit_bytes = MAX_PATH_BYTES_RST;

    int unsigned err_cnt       = 0;
    int unsigned verdicts_seen = 0;
    int unsigned cycles        = 0;
    int unsigned hold_left     = 0;
    logic        hold_done     = 1'b0;
    t_path_item  nxt;
    logic        exp_safe;

    archive_path_safety_check_unit u_top (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_cfg_valid          (cfg_valid),
        .o_cfg_ready          (cfg_ready),
        .i_cfg_max_path_bytes (cfg_data),
        .i_in_valid           (in_valid),
        .o_in_stall           (in_stall),
        .i_path_byte          (path_byte),
        .i_final_byte         (final_byte),
        .o_out_valid          (out_valid),
        .i_out_stall          (out_stall),
        .o_path_safe          (path_safe)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Path checker shadow
    // ------------------------------------------------------------------

    // A segment of one or two dots only.
    function automatic logic dot_segment();
        return seg_dots && (seg_len == 2'd1 || seg_len == 2'd2);
    endfunction

    // Walks one accepted byte through the rules; the final byte
    // queues the verdict and clears the path state.
    task automatic scan_byte(input t_byte b, input logic last);
        logic is_letter;
        is_letter = (b >= CH_UPPER_A && b <= CH_UPPER_Z) ||
                    (b >= CH_LOWER_A && b <= CH_LOWER_Z);
        if (pos_cnt == 0) begin
            if (b == CH_SLASH || b == CH_BACKSLASH)
                rejected = 1'b1;
            lead_letter = is_letter;
        end else if (pos_cnt == 1) begin
            // drive prefix: letter then colon
            if (lead_letter && b == CH_COLON)
                rejected = 1'b1;
        end
        if (b == CH_BACKSLASH || b < CH_SPACE || b == CH_DEL)
            rejected = 1'b1;
        if (b == CH_SLASH) begin
            // empty inner segment, or "." / ".." closed by a separator
            if (seg_len == 0 || dot_segment())
                rejected = 1'b1;
            seg_len  = '0;
            seg_dots = 1'b1;
        end else begin
            if (seg_len != SEG_MAX)
                seg_len = seg_len + 1'b1;
            if (b != CH_DOT)
                seg_dots = 1'b0;
        end
        if (pos_cnt != POS_MAX)
            pos_cnt = pos_cnt + 1'b1;
        if (last) begin
            // end of path closes the last segment; empty is fine there
            if (dot_segment())
                rejected = 1'b1;
            if (pos_cnt > {1'b0, limit_bytes})
                rejected = 1'b1;
            verdict_q.push_back(!rejected);
            pos_cnt     = '0;
            seg_len     = '0;
            seg_dots    = 1'b1;
            lead_letter = 1'b0;
            rejected    = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic add_byte(input t_byte b, input logic last);
        path_q.push_back('{b: b, last: last});
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(t_byte'(s[i]), i == s.len() - 1);
    endtask

    // Path of n bytes: 7-letter segments split by '/', which also
    // drives the segment length into saturation.
    task automatic add_run(input int n);
        for (int i = 0; i < n; i++)
            add_byte((i % 8 == 7) ? CH_SLASH : CH_LOWER_A + t_byte'(i % 26), i == n - 1);
    endtask

    function automatic t_byte letter_byte();
        return $urandom_range(1) ? t_byte'($urandom_range(CH_UPPER_A, CH_UPPER_Z))
                                 : t_byte'($urandom_range(CH_LOWER_A, CH_LOWER_Z));
    endfunction

    // Any byte above space that is legal inside a segment, letters and dots favored.
    function automatic t_byte name_byte();
        t_byte b;
        if ($urandom_range(9) == 0)
            return CH_DOT;
        if ($urandom_range(1) == 0)
            return letter_byte();
        do
            b = t_byte'($urandom_range(8'h21, 8'hff));
        while (b == CH_SLASH || b == CH_BACKSLASH || b == CH_DEL);
        return b;
    endfunction

    // Mostly clean relative paths with random names; about a third get
    // one flaw or are replaced by raw noise.
    task automatic add_random_path();
        t_byte p[$];
        int    n_seg;
        int    seg_n;
        t_flaw flaw;
        n_seg = $urandom_range(1, 4);
        for (int s = 0; s < n_seg; s++) begin
            if (s != 0)
                p.push_back(CH_SLASH);
            seg_n = $urandom_range(1, 5);
            for (int k = 0; k < seg_n; k++)
                p.push_back(name_byte());
        end
        if ($urandom_range(3) == 0)
            p.push_back(CH_SLASH);
        if ($urandom_range(99) < 30) begin
            flaw = t_flaw'($urandom_range(5));
            case (flaw)
                FLAW_LEAD_SEP: begin
                    p.push_front($urandom_range(1) ? CH_SLASH : CH_BACKSLASH);
                end
                FLAW_DRIVE: begin
                    p.push_front(CH_COLON);
                    p.push_front(letter_byte());
                end
                FLAW_DOT_SEG: begin
                    if ($urandom_range(1))
                        p.push_front(CH_SLASH);
                    else
                        p.push_back(CH_SLASH);
                    repeat ($urandom_range(1, 2)) begin
                        if ($urandom_range(1))
                            p.push_front(CH_DOT);
                        else
                            p.push_back(CH_DOT);
                    end
                end
                FLAW_EMPTY_SEG: begin
                    p.push_back(CH_SLASH);
                    p.push_back(CH_SLASH);
                    p.push_back(name_byte());
                end
                FLAW_BAD_BYTE: begin
                    p[$urandom_range(p.size() - 1)] = t_byte'($urandom_range(255));
                end
                default: begin
                    p.delete();
                    repeat ($urandom_range(1, 8))
                        p.push_back(t_byte'($urandom_range(255)));
                end
            endcase
        end
        foreach (p[i])
            add_byte(p[i], i == p.size() - 1);
    endtask

    // Limit register write; only called with no path in flight.
    task automatic write_limit(input t_byte v);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid   <= 1'b0;
        limit_bytes = v;
    endtask

    // Every queued byte sent and every verdict back, then settle.
    task automatic wait_idle();
        do
            @(posedge clk);
        while (path_q.size() != 0 || in_valid || verdict_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Byte driver: holds a stalled transaction, otherwise offers the
    // next byte or idles at random.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall)
                scan_byte(path_byte, final_byte);
            if (!(in_valid && in_stall)) begin
                if (path_q.size() != 0 && (calm || $urandom_range(99) >= 35)) begin
                    nxt = path_q.pop_front();
                    path_byte  <= nxt.b;
                    final_byte <= nxt.last;
                    in_valid   <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Verdict monitor and output stall. Once, after enough verdicts, the
    // output is held off long enough for the block to back up its input.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                verdicts_seen++;
                if (verdict_q.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected verdict transaction, path_safe=%0b",
                             $time, path_safe);
                end else begin
                    exp_safe = verdict_q.pop_front();
                    if (path_safe !== exp_safe) begin
                        err_cnt++;
                        $display("%0t: path_safe mismatch, expected %0b actual %0b",
                                 $time, exp_safe, path_safe);
                    end
                end
            end
            if (hold_left != 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (!hold_done && verdicts_seen >= HOLD_AFTER_VERDICTS) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                out_stall <= 1'b1;
            end else begin
                out_stall <= !calm && ($urandom_range(99) < 35);
            end
        end
    end

    // Run guard.
    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d verdicts outstanding", $time, verdict_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed paths at the reset limit: each rule alone, plus near misses.
        add_text("a");
        add_text("/a");
        add_text("\\");
        add_text("C:");
        add_text("z:x");
        add_text("1:");
        add_text("a/");
        add_text("a//b");
        add_text(".");
        add_text("./");
        add_text("a/..");
        add_text("....");
        add_text(".a");
        add_text(" ");
        add_byte(8'h00, 1'b1);
        add_byte(8'h1f, 1'b1);
        add_byte(CH_DEL, 1'b1);
        add_byte(8'hff, 1'b1);
        add_byte(8'h80, 1'b1);
        wait_idle();

        // Limit of one: only single-byte paths pass.
        write_limit(8'd1);
        add_text("a");
        add_text("ab");
        repeat (3) add_random_path();
        wait_idle();

        // Limit of zero rejects everything.
        write_limit(8'd0);
        add_text("b");
        repeat (2) add_random_path();
        wait_idle();

        // Small random limit, back-to-back traffic with no gaps; paths just
        // at and just past the limit, and the long output hold-off.
        write_limit(t_byte'($urandom_range(6, 30)));
        calm <= 1'b1;
        add_run(int'(limit_bytes));
        add_run(int'(limit_bytes) + 1);
        repeat (10) add_random_path();
        wait_idle();
        calm <= 1'b0;

        // Largest limit: a path past the counter ceiling.
        write_limit(8'd255);
        add_run(512);
        add_random_path();
        wait_idle();

        write_limit(t_byte'($urandom_range(1, 254)));
        repeat (3) add_random_path();
        wait_idle();

        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/apsc_pkg.sv
rtl/archive_path_safety_check_unit.sv
tb/sv/tb.sv
